>>> rtl/cwsg_pkg.sv
// ----------------------------------------------------------------------------
// cwsg_pkg
// Shared types, register codes and the square root step used by the circle
// window span pipeline.
// ----------------------------------------------------------------------------
package cwsg_pkg;

  localparam int unsigned PixW  = 8;
  localparam int unsigned ProdW = 2 * PixW;
  localparam int unsigned RemW  = PixW + 2;

  localparam logic [PixW-1:0] PixMax = '1;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_CENTER_X = 2'd0,
    REG_RADIUS   = 2'd1
  } reg_idx_e;

  // Square root working set that travels down the pipeline
  typedef struct packed {
    logic              in_win;
    logic [ProdW-1:0]  rad;
    logic [RemW-1:0]   rem;
    logic [PixW-1:0]   root;
  } sq_t;

  // One restoring step: bring down two radicand bits, settle one root bit
  function automatic sq_t sqrt_step(sq_t a);
    sq_t             r;
    logic [RemW-1:0] rem_n;
    logic [RemW-1:0] trial;
    r      = a;
    rem_n  = {a.rem[RemW-3:0], a.rad[ProdW-1 -: 2]};
    trial  = {a.root, 2'b01};
    r.rad  = {a.rad[ProdW-3:0], 2'b00};
    if (rem_n >= trial) begin
      r.rem  = rem_n - trial;
      r.root = {a.root[PixW-2:0], 1'b1};
    end else begin
      r.rem  = rem_n;
      r.root = {a.root[PixW-2:0], 1'b0};
    end
    return r;
  endfunction

endpackage

>>> rtl/cwsg_front.sv
// ----------------------------------------------------------------------------
// cwsg_front
// Folds the line onto the upper half, finds the offset into the circle and
// forms the squared half width t*(2r-t) over two register stages.
// ----------------------------------------------------------------------------
module cwsg_front #(
  parameter int unsigned HALF_LINES = 96
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       valid_i,
  output logic                       ready_o,
  input  logic [cwsg_pkg::PixW-1:0]  line_i,
  input  logic [cwsg_pkg::PixW-1:0]  radius_i,
  output logic                       valid_o,
  input  logic                       ready_i,
  output cwsg_pkg::sq_t              data_o
);
  import cwsg_pkg::*;

  localparam logic [PixW:0] HalfL = (PixW+1)'(HALF_LINES);
  localparam logic [PixW:0] TwoH  = (PixW+1)'(2 * HALF_LINES);

  // Stage A: fold and offset
  logic            a_valid_q;
  logic            a_inside_q, a_inside_d;
  logic [PixW-1:0] a_t_q, a_t_d;
  logic [PixW:0]   a_m_q, a_m_d;
  logic            a_ready;

  // Stage B: product
  logic             b_valid_q;
  logic             b_inside_q;
  logic [ProdW-1:0] b_prod_q, b_prod_d;

  logic [PixW:0] line_w;
  logic [PixW:0] k_w;
  logic [PixW:0] kr_w;

  always_comb begin
    line_w = {1'b0, line_i};
    if (line_w >= HalfL) begin
      k_w = TwoH - (PixW+1)'(1) - line_w;
    end else begin
      k_w = line_w;
    end
    kr_w       = k_w + {1'b0, radius_i};
    a_inside_d = (line_w < TwoH) && (kr_w >= HalfL);
    a_t_d      = PixW'(kr_w - HalfL);
    a_m_d      = {radius_i, 1'b0} - {1'b0, a_t_d};
  end

  assign b_prod_d = ProdW'({{PixW{1'b0}}, a_t_q} * {{(PixW-1){1'b0}}, a_m_q});

  assign a_ready = !b_valid_q || ready_i;
  assign ready_o = !a_valid_q || a_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
    end else begin
      if (ready_o) begin
        a_valid_q <= valid_i;
      end
      if (a_ready) begin
        b_valid_q <= a_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      a_inside_q <= a_inside_d;
      a_t_q      <= a_t_d;
      a_m_q      <= a_m_d;
    end
    if (a_ready && a_valid_q) begin
      b_inside_q <= a_inside_q;
      b_prod_q   <= b_prod_d;
    end
  end

  assign valid_o = b_valid_q;

  always_comb begin
    data_o        = '0;
    data_o.in_win = b_inside_q;
    data_o.rad    = b_prod_q;
  end

endmodule

>>> rtl/cwsg_sqrt_stage.sv
// ----------------------------------------------------------------------------
// cwsg_sqrt_stage
// One pipeline stage of the digit-by-digit square root: settles two root
// bits and registers the working set.
// ----------------------------------------------------------------------------
module cwsg_sqrt_stage (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  output logic           ready_o,
  input  cwsg_pkg::sq_t  data_i,
  output logic           valid_o,
  input  logic           ready_i,
  output cwsg_pkg::sq_t  data_o
);
  import cwsg_pkg::*;

  logic valid_q;
  sq_t  data_q, data_d;

  assign data_d  = sqrt_step(sqrt_step(data_i));
  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

>>> rtl/circle_window_span_generator.sv
// ----------------------------------------------------------------------------
// circle_window_span_generator
// Left and right window bounds for each scanline of a circular window.
// ----------------------------------------------------------------------------
// Throughput: one line per cycle unless out_stall_i holds the pipeline; the
// square root runs as four two-bit stages behind a fold stage and a multiply
// stage, then a clamp/output register.
// Reset: pipeline empties, center_x returns to 128 and radius to 0.
// ----------------------------------------------------------------------------
module circle_window_span_generator #(
  parameter int unsigned HALF_LINES = 96
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // configuration write channel
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [1:0]                 cfg_index_i,
  input  logic [cwsg_pkg::PixW-1:0]  cfg_data_i,
  // line request channel
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [cwsg_pkg::PixW-1:0]  line_i,
  // span result channel
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [cwsg_pkg::PixW-1:0]  left_edge_o,
  output logic [cwsg_pkg::PixW-1:0]  right_edge_o
);
  import cwsg_pkg::*;

  localparam int unsigned NumSq = PixW / 2;

  logic [PixW-1:0] center_x_q;
  logic [PixW-1:0] radius_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_x_q <= PixW'(128);
      radius_q   <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_CENTER_X: center_x_q <= cfg_data_i;
        REG_RADIUS:   radius_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic            front_ready;
  logic [NumSq:0]  sq_valid;
  logic [NumSq:0]  sq_ready;
  sq_t             sq_data [NumSq+1];

  cwsg_front #(
    .HALF_LINES (HALF_LINES)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (in_valid_i),
    .ready_o  (front_ready),
    .line_i   (line_i),
    .radius_i (radius_q),
    .valid_o  (sq_valid[0]),
    .ready_i  (sq_ready[0]),
    .data_o   (sq_data[0])
  );

  assign in_stall_o = !front_ready;

  for (genvar g = 0; g < NumSq; g++) begin : g_sqrt
    cwsg_sqrt_stage u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (sq_valid[g]),
      .ready_o (sq_ready[g]),
      .data_i  (sq_data[g]),
      .valid_o (sq_valid[g+1]),
      .ready_i (sq_ready[g+1]),
      .data_o  (sq_data[g+1])
    );
  end

  // Clamp and output register
  logic            out_valid_q;
  logic [PixW-1:0] left_q, left_d;
  logic [PixW-1:0] right_q, right_d;
  logic [PixW:0]   sum_w;
  logic [PixW-1:0] s_w;
  logic            out_ready;

  assign out_ready        = !out_valid_q || !out_stall_i;
  assign sq_ready[NumSq]  = out_ready;

  always_comb begin
    s_w   = sq_data[NumSq].root;
    sum_w = {1'b0, center_x_q} + {1'b0, s_w};
    if (!sq_data[NumSq].in_win) begin
      left_d  = '0;
      right_d = '0;
    end else begin
      left_d  = (center_x_q >= s_w) ? (center_x_q - s_w) : '0;
      right_d = sum_w[PixW] ? PixMax : sum_w[PixW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_ready) begin
      out_valid_q <= sq_valid[NumSq];
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ready && sq_valid[NumSq]) begin
      left_q  <= left_d;
      right_q <= right_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign left_edge_o  = left_q;
  assign right_edge_o = right_q;

endmodule
